/* rtl/ip5t_pkg.sv */
// Shared types, codes and constants of the IPv4 five-tuple extractor.
`default_nettype none

package ip5t_pkg;

	localparam int MAX_CAPTURE_DEF = 2048;
	localparam int QUEUE_DEPTH_DEF = 2;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CSUM_CHECK = 1'd1;

	// link header modes
	localparam logic [1:0] MODE_RAW  = 2'd0;
	localparam logic [1:0] MODE_NULL = 2'd1;
	localparam logic [1:0] MODE_ETH  = 2'd2;
	localparam logic [1:0] MODE_BAD  = 2'd3;
	localparam logic [1:0] MODE_RESET = MODE_ETH;
	localparam logic       CSUM_CHECK_RESET = 1'b1;

	// link header lengths
	localparam logic [4:0] LINK_LEN_NONE = 5'd0;
	localparam logic [4:0] LINK_LEN_NULL = 5'd4;
	localparam logic [4:0] LINK_LEN_ETH  = 5'd14;
	localparam logic [4:0] LINK_LEN_VLAN = 5'd18;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_VLAN_TAG = 16'h8100;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [3:0]  IP_VERSION_4 = 4'd4;
	localparam logic [15:0] CSUM_GOOD    = 16'hFFFF;

	// transport header bytes that must be captured
	localparam logic [6:0] TCP_MIN_BYTES = 7'd13;
	localparam logic [6:0] L4_MIN_BYTES  = 7'd8;

	// per-packet header state, also the record handed to the back end
	typedef struct packed {
		logic        link_ok;
		logic [4:0]  link_len;
		logic [3:0]  version;
		logic [3:0]  hdr_words;
		logic [3:0]  tcp_doff;
		logic [7:0]  proto;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] l4_sport;
		logic [15:0] l4_dport;
		logic [15:0] total_len;
		logic [15:0] csum;
	} ip5t_hdr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ip5t_qstat_t;

endpackage

`default_nettype wire

/* rtl/ip5t_front.sv */
// Byte parser: walks link and IPv4/L4 headers, emits a header record per packet.
`default_nettype none

module ip5t_front import ip5t_pkg::*; #(
	parameter int MAX_CAPTURE = MAX_CAPTURE_DEF,
	localparam int OFF_W = $clog2(MAX_CAPTURE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       link_mode,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       pkt_byte,
	input  logic             last_byte,
	input  ip5t_qstat_t      qstat,
	output logic             push,
	output ip5t_hdr_t        push_hdr,
	output logic [OFF_W-1:0] push_off
);

	localparam ip5t_hdr_t HDR_CLEAR = '{link_ok: 1'b1, default: '0};

	// byte positions inside the link header
	localparam logic [OFF_W-1:0] OFF_NULL_TYPE_HI = OFF_W'(2);
	localparam logic [OFF_W-1:0] OFF_NULL_TYPE_LO = OFF_W'(3);
	localparam logic [OFF_W-1:0] OFF_ETH_TYPE_HI  = OFF_W'(12);
	localparam logic [OFF_W-1:0] OFF_ETH_TYPE_LO  = OFF_W'(13);

	// byte positions inside the IP and transport headers
	localparam logic [OFF_W-1:0] IP_TLEN_HI = OFF_W'(2);
	localparam logic [OFF_W-1:0] IP_TLEN_LO = OFF_W'(3);
	localparam logic [OFF_W-1:0] IP_PROTO   = OFF_W'(9);
	localparam logic [OFF_W-1:0] IP_SRC_LO  = OFF_W'(12);
	localparam logic [OFF_W-1:0] IP_DST_LO  = OFF_W'(16);
	localparam logic [OFF_W-1:0] IP_DST_END = OFF_W'(20);
	localparam logic [OFF_W-1:0] L4_SPORT_HI = OFF_W'(0);
	localparam logic [OFF_W-1:0] L4_SPORT_LO = OFF_W'(1);
	localparam logic [OFF_W-1:0] L4_DPORT_HI = OFF_W'(2);
	localparam logic [OFF_W-1:0] L4_DPORT_LO = OFF_W'(3);
	localparam logic [OFF_W-1:0] L4_TCP_DOFF = OFF_W'(12);

	logic [OFF_W-1:0] off_q;
	logic [OFF_W-1:0] off_d;
	ip5t_hdr_t        hdr_q;
	ip5t_hdr_t        nxt;
	logic [7:0]       held_q;
	logic [7:0]       held_d;
	logic             take;
	logic             accept;
	logic [OFF_W-1:0] ip_p;
	logic [3:0]       hw;
	logic [5:0]       hl4;
	logic [OFF_W-1:0] l4_t;
	logic [16:0]      csum_sum;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;
	assign take     = off_q < OFF_W'(MAX_CAPTURE);
	assign csum_sum = {1'b0, hdr_q.csum} + {1'b0, held_q, pkt_byte};

	always_comb begin
		nxt    = hdr_q;
		held_d = held_q;
		off_d  = off_q;
		ip_p   = '0;
		hw     = hdr_q.hdr_words;
		hl4    = '0;
		l4_t   = '0;
		if (take) begin
			// link mode is latched on the first byte
			if (off_q == '0) begin
				unique case (link_mode)
					MODE_RAW:  nxt.link_len = LINK_LEN_NONE;
					MODE_NULL: nxt.link_len = LINK_LEN_NULL;
					MODE_ETH:  nxt.link_len = LINK_LEN_ETH;
					MODE_BAD: begin
						nxt.link_len = LINK_LEN_NONE;
						nxt.link_ok  = 1'b0;
					end
				endcase
			end
			if (nxt.link_len == LINK_LEN_NULL && off_q == OFF_NULL_TYPE_HI)
				held_d = pkt_byte;
			if (nxt.link_len == LINK_LEN_NULL && off_q == OFF_NULL_TYPE_LO &&
					{held_q, pkt_byte} != ETHERTYPE_IPV4)
				nxt.link_ok = 1'b0;
			if (nxt.link_len == LINK_LEN_ETH && off_q == OFF_ETH_TYPE_HI)
				held_d = pkt_byte;
			if (nxt.link_len == LINK_LEN_ETH && off_q == OFF_ETH_TYPE_LO) begin
				if ({held_q, pkt_byte} == ETYPE_VLAN_TAG)
					nxt.link_len = LINK_LEN_VLAN;
				else if ({held_q, pkt_byte} != ETHERTYPE_IPV4)
					nxt.link_ok = 1'b0;
			end

			if (off_q >= OFF_W'(nxt.link_len)) begin
				ip_p = off_q - OFF_W'(nxt.link_len);
				hw   = (ip_p == '0) ? pkt_byte[3:0] : hdr_q.hdr_words;
				hl4  = {hw, 2'b00};
				l4_t = ip_p - OFF_W'(hl4);

				if (ip_p == '0) begin
					nxt.version   = pkt_byte[7:4];
					nxt.hdr_words = pkt_byte[3:0];
				end
				if (ip_p == IP_TLEN_HI)
					nxt.total_len = {pkt_byte, 8'h00};
				if (ip_p == IP_TLEN_LO)
					nxt.total_len = hdr_q.total_len | {8'h00, pkt_byte};
				if (ip_p == IP_PROTO)
					nxt.proto = pkt_byte;
				if (ip_p >= IP_SRC_LO && ip_p < IP_DST_LO)
					nxt.src_ip = {hdr_q.src_ip[23:0], pkt_byte};
				if (ip_p >= IP_DST_LO && ip_p < IP_DST_END)
					nxt.dst_ip = {hdr_q.dst_ip[23:0], pkt_byte};

				if (ip_p < OFF_W'(hl4)) begin
					// ones-complement sum over 16-bit header words
					if (!ip_p[0])
						held_d = pkt_byte;
					else
						nxt.csum = csum_sum[15:0] + {15'd0, csum_sum[16]};
				end else begin
					if (l4_t == L4_SPORT_HI)
						nxt.l4_sport = {pkt_byte, 8'h00};
					if (l4_t == L4_SPORT_LO)
						nxt.l4_sport = hdr_q.l4_sport | {8'h00, pkt_byte};
					if (l4_t == L4_DPORT_HI)
						nxt.l4_dport = {pkt_byte, 8'h00};
					if (l4_t == L4_DPORT_LO)
						nxt.l4_dport = hdr_q.l4_dport | {8'h00, pkt_byte};
					if (l4_t == L4_TCP_DOFF)
						nxt.tcp_doff = pkt_byte[7:4];
				end
			end
			off_d = off_q + OFF_W'(1);
		end
	end

	assign push     = accept && last_byte;
	assign push_hdr = nxt;
	assign push_off = off_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			hdr_q  <= HDR_CLEAR;
			held_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				off_q  <= '0;
				hdr_q  <= HDR_CLEAR;
				held_q <= '0;
			end else begin
				off_q  <= off_d;
				hdr_q  <= nxt;
				held_q <= held_d;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/ip5t_queue.sv */
// Short FIFO of per-packet header records between parser and result stage.
`default_nettype none

module ip5t_queue import ip5t_pkg::*; #(
	parameter int WIDTH = $bits(ip5t_hdr_t),
	parameter int DEPTH = QUEUE_DEPTH_DEF,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output ip5t_qstat_t      qstat
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign qstat.full  = cnt_q == CNT_W'(DEPTH);
	assign qstat.empty = cnt_q == '0;
	assign pop_data    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full header queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty header queue");
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !qstat.empty)
		else $error("pushed record missing from header queue");
`endif

endmodule

`default_nettype wire

/* rtl/ip5t_back.sv */
// Result stage: final header checks and the registered result beat.
`default_nettype none

module ip5t_back import ip5t_pkg::*; #(
	parameter int MAX_CAPTURE = MAX_CAPTURE_DEF,
	localparam int OFF_W = $clog2(MAX_CAPTURE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             csum_check,
	input  ip5t_qstat_t      qstat,
	input  ip5t_hdr_t        head_hdr,
	input  logic [OFF_W-1:0] head_off,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             valid_res,
	output logic [31:0]      src_ip,
	output logic [31:0]      dst_ip,
	output logic [15:0]      l4_sport,
	output logic [15:0]      l4_dport,
	output logic [7:0]       protocol,
	output logic [15:0]      ip_total_length
);

	logic             out_valid_q;
	logic             valid_res_q;
	logic [31:0]      src_ip_q;
	logic [31:0]      dst_ip_q;
	logic [15:0]      l4_sport_q;
	logic [15:0]      l4_dport_q;
	logic [7:0]       proto_q;
	logic [15:0]      tlen_q;

	logic             link_fit;
	logic [OFF_W-1:0] ip_len;
	logic [6:0]       hl4;
	logic [6:0]       tcp_need;
	logic [6:0]       tcp_min;
	logic [6:0]       l4_min;
	logic             l4_ok;
	logic             ok;
	logic             ported;

	assign link_fit = head_off >= OFF_W'(head_hdr.link_len);
	assign ip_len   = head_off - OFF_W'(head_hdr.link_len);
	assign hl4      = {1'b0, head_hdr.hdr_words, 2'b00};
	assign tcp_need = hl4 + {1'b0, head_hdr.tcp_doff, 2'b00};
	assign tcp_min  = hl4 + TCP_MIN_BYTES;
	assign l4_min   = hl4 + L4_MIN_BYTES;

	always_comb begin
		l4_ok = 1'b1;
		unique if (head_hdr.proto == PROTO_TCP)
			l4_ok = ip_len >= OFF_W'(tcp_min) && ip_len >= OFF_W'(tcp_need);
		else if (head_hdr.proto == PROTO_UDP || head_hdr.proto == PROTO_ICMP)
			l4_ok = ip_len >= OFF_W'(l4_min);
		else
			l4_ok = 1'b1;
	end

	assign ok = head_hdr.link_ok && link_fit && ip_len >= OFF_W'(hl4) &&
		head_hdr.version == IP_VERSION_4 &&
		!(csum_check && head_hdr.csum != CSUM_GOOD) && l4_ok;
	assign ported = head_hdr.proto == PROTO_TCP || head_hdr.proto == PROTO_UDP;

	// output register frees as soon as the current beat is taken
	assign pop = !qstat.empty && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			valid_res_q <= ok;
			src_ip_q    <= ok ? head_hdr.src_ip : '0;
			dst_ip_q    <= ok ? head_hdr.dst_ip : '0;
			l4_sport_q  <= (ok && ported) ? head_hdr.l4_sport : '0;
			l4_dport_q  <= (ok && ported) ? head_hdr.l4_dport : '0;
			proto_q     <= ok ? head_hdr.proto : '0;
			tlen_q      <= ok ? head_hdr.total_len : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign valid_res       = valid_res_q;
	assign src_ip          = src_ip_q;
	assign dst_ip          = dst_ip_q;
	assign l4_sport        = l4_sport_q;
	assign l4_dport        = l4_dport_q;
	assign protocol        = proto_q;
	assign ip_total_length = tlen_q;

endmodule

`default_nettype wire

/* rtl/ipv4_five_tuple_extractor_core.sv */
// Top level of the IPv4 five-tuple extractor: config registers and block wiring.
// Usage:
//  - Input channel (in_valid/in_stall): one captured packet byte per beat, link
//    header first, last_byte set on the final byte of the packet.
//  - Output channel (out_valid/out_stall): one result beat per packet, carrying
//    valid_res and, for a valid packet, addresses, ports (TCP/UDP only),
//    protocol and IP total length; all fields are zero for an invalid packet.
//  - Config port: cfg_wr_en writes cfg_data into register cfg_index
//    (0 link header mode, 1 checksum check); write only while idle.
//  - Throughput: one byte per cycle unless stalled, back-to-back packets, no gap.
//  - The last byte's record is written into the record queue, then popped
//    into the registered result stage once that stage is free.
//  - Only the first MAX_CAPTURE bytes of a packet are parsed; later bytes are
//    taken and dropped, and the counted length saturates there.
//  - A QUEUE_DEPTH-entry record queue sits between parser and result stage;
//    in_stall rises only when that queue is full, i.e. once out_stall holds
//    one result in the output register and QUEUE_DEPTH more packets have ended.
//  - Reset: link mode Ethernet, checksum check on, parser at packet start,
//    queue and output empty.
`default_nettype none

module ipv4_five_tuple_extractor_core import ip5t_pkg::*; #(
	parameter int MAX_CAPTURE = MAX_CAPTURE_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            pkt_byte,
	input  logic                  last_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  valid_res,
	output logic [31:0]           src_ip,
	output logic [31:0]           dst_ip,
	output logic [15:0]           l4_sport,
	output logic [15:0]           l4_dport,
	output logic [7:0]            protocol,
	output logic [15:0]           ip_total_length
);

	localparam int OFF_W = $clog2(MAX_CAPTURE + 1);
	localparam int QW    = $bits(ip5t_hdr_t) + OFF_W;

	logic [1:0]       link_mode_q;
	logic             csum_check_q;

	logic             push;
	ip5t_hdr_t        push_hdr;
	logic [OFF_W-1:0] push_off;
	logic             pop;
	logic [QW-1:0]    head_data;
	ip5t_hdr_t        head_hdr;
	logic [OFF_W-1:0] head_off;
	ip5t_qstat_t      qstat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_mode_q  <= MODE_RESET;
			csum_check_q <= CSUM_CHECK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LINK_MODE:  link_mode_q  <= cfg_data[1:0];
				REG_CSUM_CHECK: csum_check_q <= cfg_data[0];
			endcase
		end
	end

	// front: byte parser
	ip5t_front #(
		.MAX_CAPTURE (MAX_CAPTURE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.link_mode (link_mode_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pkt_byte  (pkt_byte),
		.last_byte (last_byte),
		.qstat     (qstat),
		.push      (push),
		.push_hdr  (push_hdr),
		.push_off  (push_off)
	);

	// record queue decouples parser from result stage
	ip5t_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_hdr, push_off}),
		.pop       (pop),
		.pop_data  (head_data),
		.qstat     (qstat)
	);

	assign head_hdr = head_data[QW-1:OFF_W];
	assign head_off = head_data[OFF_W-1:0];

	// back: checks and result beat
	ip5t_back #(
		.MAX_CAPTURE (MAX_CAPTURE)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.csum_check      (csum_check_q),
		.qstat           (qstat),
		.head_hdr        (head_hdr),
		.head_off        (head_off),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.valid_res       (valid_res),
		.src_ip          (src_ip),
		.dst_ip          (dst_ip),
		.l4_sport        (l4_sport),
		.l4_dport        (l4_dport),
		.protocol        (protocol),
		.ip_total_length (ip_total_length)
	);

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench of the IPv4 five-tuple extractor core.
module testbench;
	import ip5t_pkg::*;

	// Run limits and pacing
	localparam int unsigned LIMIT_CYCLES = 400_000; // watchdog, far above the slowest run
	localparam int          SETTLE_CYCLES = 8;      // parser + queue + result stage, with margin
	localparam int          HOLD_CYCLES = 400;      // long receiver hold-off
	localparam int          PHASE_BYTES = 100;      // minimum random bytes per random phase
	localparam int          MAX_REPORTS = 10;
	localparam int          RAND_PHASES = 8;

	// Idle mixes cycled through the phases
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mix_t;

	// One input beat waiting to be driven
	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_beat_t;

	// One result beat as the block should present it
	typedef struct {
		logic        ok;
		logic [31:0] sip;
		logic [31:0] dip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  proto;
		logic [15:0] tlen;
	} five_tuple_t;

	// Shape of one generated packet
	typedef struct {
		logic [3:0] version;
		logic [3:0] ihl;
		logic [3:0] doff;
		logic [7:0] proto;
		bit         csum_ok;
		bit         link_bad;
		bit         vlan;
		bit         tlen_rand;
		int         payload;
		int         cut;       // captured length, 0 keeps the whole packet
	} pkt_spec_t;

	// DUT signals, the driven inputs known from time zero
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_LINK_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            pkt_byte = 8'h00;
	logic                  last_byte = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  valid_res;
	logic [31:0]           src_ip;
	logic [31:0]           dst_ip;
	logic [15:0]           l4_sport;
	logic [15:0]           l4_dport;
	logic [7:0]            protocol;
	logic [15:0]           ip_total_length;

	// Stimulus and scoreboard storage
	byte_beat_t  bytes_to_send[$];
	five_tuple_t tuples_due[$];
	logic [7:0]  pkt_bytes[$];     // packet under construction

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          hold_req = 1'b0;  // toggled by the stimulus to start a long hold-off
	bit          hold_seen = 1'b0;
	int          hold_left = 0;
	int unsigned miss_cnt = 0;
	int unsigned cycle_cnt = 0;

	// Predictor copy of the configuration
	logic [1:0]  cfg_mode = MODE_RESET;
	logic        cfg_chk = CSUM_CHECK_RESET;

	// Predictor copy of the per-packet parse state
	int unsigned hdr_off;
	logic [4:0]  hdr_link;
	logic        hdr_link_ok;
	logic [7:0]  hdr_held;
	logic [3:0]  hdr_ver;
	logic [3:0]  hdr_words;
	logic [3:0]  hdr_doff;
	logic [7:0]  hdr_proto;
	logic [31:0] hdr_sip;
	logic [31:0] hdr_dip;
	logic [15:0] hdr_sport;
	logic [15:0] hdr_dport;
	logic [15:0] hdr_tlen;
	int unsigned hdr_csum;

	ipv4_five_tuple_extractor_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pkt_byte(pkt_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.valid_res(valid_res),
		.src_ip(src_ip),
		.dst_ip(dst_ip),
		.l4_sport(l4_sport),
		.l4_dport(l4_dport),
		.protocol(protocol),
		.ip_total_length(ip_total_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_parse();
		hdr_off = 0;
		hdr_link = LINK_LEN_NONE;
		hdr_link_ok = 1'b1;
		hdr_held = 8'h00;
		hdr_ver = 4'h0;
		hdr_words = 4'h0;
		hdr_doff = 4'h0;
		hdr_proto = 8'h00;
		hdr_sip = 32'h0;
		hdr_dip = 32'h0;
		hdr_sport = 16'h0;
		hdr_dport = 16'h0;
		hdr_tlen = 16'h0;
		hdr_csum = 0;
	endfunction

	// Parse one captured byte into the header state.
	function automatic void absorb_byte(input logic [7:0] b);
		int unsigned off, p, hw, hl4, t;
		logic [15:0] etype;
		off = hdr_off;
		// link mode is latched on the first byte of the packet
		if (off == 0) begin
			case (cfg_mode)
				MODE_NULL: hdr_link = LINK_LEN_NULL;
				MODE_ETH:  hdr_link = LINK_LEN_ETH;
				default:   hdr_link = LINK_LEN_NONE;
			endcase
			if (cfg_mode == MODE_BAD)
				hdr_link_ok = 1'b0;
		end
		etype = {hdr_held, b};
		if (hdr_link == LINK_LEN_NULL && off == 2)
			hdr_held = b;
		if (hdr_link == LINK_LEN_NULL && off == 3 && etype != ETHERTYPE_IPV4)
			hdr_link_ok = 1'b0;
		if (hdr_link == LINK_LEN_ETH && off == 12)
			hdr_held = b;
		if (hdr_link == LINK_LEN_ETH && off == 13) begin
			// a VLAN tag grows the link header; the inner type goes unchecked
			if (etype == ETYPE_VLAN_TAG)
				hdr_link = LINK_LEN_VLAN;
			else if (etype != ETHERTYPE_IPV4)
				hdr_link_ok = 1'b0;
		end
		if (off >= hdr_link) begin
			p = off - hdr_link;
			hw = (p == 0) ? b[3:0] : hdr_words;
			hl4 = hw * 4;
			if (p == 0)
				{hdr_ver, hdr_words} = b;
			if (p == 2)
				hdr_tlen = {b, 8'h00};
			if (p == 3)
				hdr_tlen = hdr_tlen | {8'h00, b};
			if (p == 9)
				hdr_proto = b;
			if (p >= 12 && p < 16)
				hdr_sip = {hdr_sip[23:0], b};
			if (p >= 16 && p < 20)
				hdr_dip = {hdr_dip[23:0], b};
			if (p < hl4) begin
				// running one's-complement sum over the IP header words
				if (p % 2 == 0) begin
					hdr_held = b;
				end else begin
					hdr_csum = hdr_csum + {hdr_held, b};
					hdr_csum = (hdr_csum & 32'hFFFF) + (hdr_csum >> 16);
				end
			end else begin
				// transport header starts right after the IP header length,
				// even when that length overlaps the fixed IP fields
				t = p - hl4;
				if (t == 0)
					hdr_sport = {b, 8'h00};
				if (t == 1)
					hdr_sport = hdr_sport | {8'h00, b};
				if (t == 2)
					hdr_dport = {b, 8'h00};
				if (t == 3)
					hdr_dport = hdr_dport | {8'h00, b};
				if (t == 12)
					hdr_doff = b[7:4];
			end
		end
		hdr_off = off + 1;
	endfunction

	// Feed one accepted beat; on the final byte produce the expected tuple.
	function automatic void parse_beat(input logic [7:0] b, input logic last,
			output bit has_tuple, output five_tuple_t tup);
		bit          ok;
		bit          ported;
		int unsigned len, hl4;
		has_tuple = 1'b0;
		tup = '{default: '0};
		// bytes past the capture limit are dropped
		if (hdr_off < MAX_CAPTURE_DEF)
			absorb_byte(b);
		if (last) begin
			has_tuple = 1'b1;
			ok = hdr_link_ok && hdr_off >= hdr_link;
			len = ok ? hdr_off - hdr_link : 0;
			hl4 = hdr_words * 4;
			if (len < hl4)
				ok = 1'b0;
			if (hdr_ver != IP_VERSION_4)
				ok = 1'b0;
			if (cfg_chk && hdr_csum != CSUM_GOOD)
				ok = 1'b0;
			if (hdr_proto == PROTO_TCP) begin
				if (len < hl4 + TCP_MIN_BYTES || len < hl4 + hdr_doff * 4)
					ok = 1'b0;
			end else if (hdr_proto == PROTO_UDP || hdr_proto == PROTO_ICMP) begin
				if (len < hl4 + L4_MIN_BYTES)
					ok = 1'b0;
			end
			if (ok) begin
				ported = hdr_proto == PROTO_TCP || hdr_proto == PROTO_UDP;
				tup.ok = 1'b1;
				tup.sip = hdr_sip;
				tup.dip = hdr_dip;
				tup.sport = ported ? hdr_sport : 16'h0;
				tup.dport = ported ? hdr_dport : 16'h0;
				tup.proto = hdr_proto;
				tup.tlen = hdr_tlen;
			end
			clear_parse();
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents queued beats, predicts on every accepted beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_bytes
		five_tuple_t tup;
		bit          has_tuple;
		byte_beat_t  nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_beat(pkt_byte, last_byte, has_tuple, tup);
				if (has_tuple)
					tuples_due.push_back(tup);
			end
			// a stalled beat stays put; otherwise offer the next one or idle
			if (!in_valid || !in_stall) begin
				if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = bytes_to_send.pop_front();
					in_valid <= 1'b1;
					pkt_byte <= nxt.data;
					last_byte <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall: random, or a long counted hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_stall
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compares each result beat with the oldest expectation
	// ------------------------------------------------------------------
	function automatic void flag_miss(string what, logic [31:0] want, logic [31:0] got);
		miss_cnt++;
		if (miss_cnt <= MAX_REPORTS)
			$display("mismatch on %s at cycle %0d: expected %h, got %h",
				what, cycle_cnt, want, got);
	endfunction

	always @(posedge clk) begin : check_tuples
		five_tuple_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tuples_due.size() == 0) begin
				flag_miss("result beat with nothing pending", 32'h0, 32'h1);
			end else begin
				want = tuples_due.pop_front();
				if (valid_res !== want.ok)
					flag_miss("valid_res", want.ok, valid_res);
				if (src_ip !== want.sip)
					flag_miss("src_ip", want.sip, src_ip);
				if (dst_ip !== want.dip)
					flag_miss("dst_ip", want.dip, dst_ip);
				if (l4_sport !== want.sport)
					flag_miss("l4_sport", want.sport, l4_sport);
				if (l4_dport !== want.dport)
					flag_miss("l4_dport", want.dport, l4_dport);
				if (protocol !== want.proto)
					flag_miss("protocol", want.proto, protocol);
				if (ip_total_length !== want.tlen)
					flag_miss("ip_total_length", want.tlen, ip_total_length);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Packet construction
	// ------------------------------------------------------------------

	function automatic logic [7:0] rand8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic pkt_spec_t base_spec(input logic [7:0] proto);
		pkt_spec_t s;
		s.version = IP_VERSION_4;
		s.ihl = 4'd5;
		s.doff = 4'd5;
		s.proto = proto;
		s.csum_ok = 1'b1;
		s.link_bad = 1'b0;
		s.vlan = 1'b0;
		s.tlen_rand = 1'b0;
		s.payload = 6;
		s.cut = 0;
		return s;
	endfunction

	// Mostly well-formed packets with random content, a share of them broken.
	function automatic pkt_spec_t random_spec();
		pkt_spec_t s;
		int        r;
		r = $urandom_range(0, 99);
		s = base_spec(r < 35 ? PROTO_TCP : r < 65 ? PROTO_UDP : r < 80 ? PROTO_ICMP : rand8());
		if ($urandom_range(0, 99) >= 90)
			s.version = 4'($urandom_range(0, 15));
		r = $urandom_range(0, 99);
		if (r >= 85)
			s.ihl = 4'($urandom_range(0, 4));
		else if (r >= 60)
			s.ihl = 4'($urandom_range(6, 15));
		if ($urandom_range(0, 99) >= 60)
			s.doff = 4'($urandom_range(0, 15));
		s.csum_ok = $urandom_range(0, 99) < 85;
		s.link_bad = $urandom_range(0, 99) < 8;
		s.vlan = $urandom_range(0, 99) < 25;
		s.tlen_rand = $urandom_range(0, 99) < 20;
		s.payload = $urandom_range(0, 16);
		s.cut = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 80) : 0;
		return s;
	endfunction

	// Build a packet for the current link mode into pkt_bytes.
	task automatic build_packet(input pkt_spec_t s);
		logic [7:0]  ip[$];
		logic [7:0]  l4[$];
		logic [15:0] etype;
		logic [15:0] tot;
		int unsigned sum;
		int          hl, n, i;
		pkt_bytes.delete();
		etype = s.link_bad ? 16'h86DD : ETHERTYPE_IPV4;
		if (cfg_mode == MODE_NULL) begin
			pkt_bytes.push_back(rand8());
			pkt_bytes.push_back(rand8());
			pkt_bytes.push_back(etype[15:8]);
			pkt_bytes.push_back(etype[7:0]);
		end else if (cfg_mode == MODE_ETH) begin
			for (i = 0; i < 12; i++)
				pkt_bytes.push_back(rand8());
			if (s.vlan) begin
				pkt_bytes.push_back(ETYPE_VLAN_TAG[15:8]);
				pkt_bytes.push_back(ETYPE_VLAN_TAG[7:0]);
				pkt_bytes.push_back(rand8());
				pkt_bytes.push_back(rand8());
			end
			pkt_bytes.push_back(etype[15:8]);
			pkt_bytes.push_back(etype[7:0]);
		end
		// transport header
		case (s.proto)
			PROTO_TCP: begin
				for (i = 0; i < 20; i++)
					l4.push_back(rand8());
				l4[12] = {s.doff, 4'(rand8())};
				for (i = 20; i < s.doff * 4; i++)
					l4.push_back(rand8());
			end
			PROTO_UDP, PROTO_ICMP: begin
				for (i = 0; i < 8; i++)
					l4.push_back(rand8());
			end
			default: begin
				n = $urandom_range(0, 12);
				for (i = 0; i < n; i++)
					l4.push_back(rand8());
			end
		endcase
		for (i = 0; i < s.payload; i++)
			l4.push_back(rand8());
		// IP header, at least the fixed 20 bytes even for a short length
		hl = s.ihl * 4;
		n = (hl > 20) ? hl : 20;
		for (i = 0; i < n; i++)
			ip.push_back(rand8());
		ip[0] = {s.version, s.ihl};
		tot = 16'(n + l4.size());
		if (s.tlen_rand)
			tot = 16'($urandom_range(0, 16'hFFFF));
		ip[2] = tot[15:8];
		ip[3] = tot[7:0];
		ip[9] = s.proto;
		if (s.ihl >= 5) begin
			ip[10] = 8'h00;
			ip[11] = 8'h00;
			sum = 0;
			for (i = 0; i < hl; i += 2) begin
				sum = sum + {ip[i], ip[i + 1]};
				sum = (sum & 32'hFFFF) + (sum >> 16);
			end
			sum = ~sum & 32'hFFFF;
			if (!s.csum_ok)
				sum = sum ^ $urandom_range(1, 16'hFFFF);
			ip[10] = sum[15:8];
			ip[11] = sum[7:0];
		end
		for (i = 0; i < ip.size(); i++)
			pkt_bytes.push_back(ip[i]);
		for (i = 0; i < l4.size(); i++)
			pkt_bytes.push_back(l4[i]);
		// truncated capture
		while (s.cut > 0 && pkt_bytes.size() > s.cut)
			void'(pkt_bytes.pop_back());
	endtask

	// Hand pkt_bytes[lo..hi-1] to the driver; the packet's final byte is marked.
	task automatic queue_bytes(input int lo, input int hi);
		byte_beat_t bt;
		int         i;
		for (i = lo; i < hi; i++) begin
			bt.data = pkt_bytes[i];
			bt.last = (i == pkt_bytes.size() - 1);
			bytes_to_send.push_back(bt);
		end
	endtask

	task automatic send_packet(input pkt_spec_t s);
		build_packet(s);
		queue_bytes(0, pkt_bytes.size());
	endtask

	// Unstructured bytes; pattern below zero means random content.
	task automatic send_filler(input int n, input int pattern);
		int i;
		pkt_bytes.delete();
		for (i = 0; i < n; i++)
			pkt_bytes.push_back(pattern < 0 ? rand8() : 8'(pattern));
		queue_bytes(0, n);
	endtask

	// ------------------------------------------------------------------
	// Sequencing
	// ------------------------------------------------------------------

	// Sender holds until everything queued is taken and every result is in.
	task automatic wait_for_results();
		while (bytes_to_send.size() != 0 || in_valid || tuples_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_LINK_MODE)
			cfg_mode = val;
		else
			cfg_chk = val[0];
		@(negedge clk);
	endtask

	task automatic set_idle(input idle_mix_t mix);
		case (mix)
			IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 70; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 70; end
			default:       begin send_idle_pct = 37; stall_pct = 37; end
		endcase
	endtask

	// New settings only once the block has gone quiet.
	task automatic start_phase(input logic [1:0] mode, input logic chk, input idle_mix_t mix);
		wait_for_results();
		write_reg(REG_LINK_MODE, mode);
		write_reg(REG_CSUM_CHECK, {1'b0, chk});
		set_idle(mix);
	endtask

	initial begin : stimulus
		pkt_spec_t s;
		int        k, sent, split;
		bit        paused;
		clear_parse();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: Ethernet, checksum checked.
		s = base_spec(PROTO_TCP);
		send_packet(s);
		s = base_spec(PROTO_UDP);
		s.vlan = 1'b1;
		send_packet(s);
		s.link_bad = 1'b1;              // tagged frame: inner type is not checked
		send_packet(s);
		s = base_spec(PROTO_ICMP);
		send_packet(s);
		s = base_spec(8'd47);           // no ports for other protocols
		s.ihl = 4'd15;
		send_packet(s);
		s = base_spec(PROTO_TCP);
		s.csum_ok = 1'b0;
		send_packet(s);
		s = base_spec(PROTO_UDP);
		s.link_bad = 1'b1;
		send_packet(s);
		s = base_spec(PROTO_TCP);
		s.version = 4'd6;
		send_packet(s);
		s = base_spec(PROTO_TCP);       // TCP data-offset byte just missed
		s.cut = 14 + 20 + 12;
		send_packet(s);
		s.cut = 14 + 20 + 13;           // and just captured
		send_packet(s);
		s = base_spec(PROTO_TCP);       // options claimed but cut off
		s.doff = 4'd15;
		s.cut = 14 + 20 + 40;
		send_packet(s);
		s = base_spec(PROTO_UDP);       // UDP header one byte short
		s.cut = 14 + 20 + 7;
		send_packet(s);
		s = base_spec(PROTO_TCP);       // IP header cut
		s.cut = 14 + 10;
		send_packet(s);
		s.cut = 5;                      // shorter than the link header
		send_packet(s);
		send_filler(1, -1);
		send_filler(30, 8'hFF);
		send_filler(30, 8'h00);
		s = base_spec(PROTO_UDP);
		s.tlen_rand = 1'b1;
		send_packet(s);

		// Raw IP, no checksum check: overlapping and odd header lengths.
		start_phase(MODE_RAW, 1'b0, IDLE_NONE);
		s = base_spec(PROTO_TCP);
		s.ihl = 4'd0;
		send_packet(s);
		s = base_spec(PROTO_UDP);
		s.ihl = 4'd3;
		send_packet(s);
		s = base_spec(PROTO_TCP);
		s.csum_ok = 1'b0;
		s.doff = 4'd0;
		send_packet(s);

		// Null link header; settings change in the middle of a packet.
		start_phase(MODE_NULL, 1'b1, IDLE_NONE);
		s = base_spec(PROTO_UDP);
		s.link_bad = 1'b1;
		send_packet(s);
		s = base_spec(PROTO_TCP);
		build_packet(s);
		queue_bytes(0, 10);
		// mode stays latched for this packet, the check setting is taken at its end
		start_phase(MODE_ETH, 1'b0, IDLE_NONE);
		queue_bytes(10, pkt_bytes.size());

		start_phase(MODE_BAD, 1'b1, IDLE_NONE);
		send_packet(base_spec(PROTO_TCP));

		// Random phases over all settings and idle mixes.
		for (k = 0; k < RAND_PHASES; k++) begin
			start_phase(2'(k % 4), 1'(k / 4), idle_mix_t'((k + k / 4) % 4));
			// one phase opens with a long receiver hold so the input backs up
			if (k == 2)
				hold_req = ~hold_req;
			sent = 0;
			paused = 1'b0;
			split = PHASE_BYTES / 2;
			while (sent < PHASE_BYTES) begin
				// one phase has the sender stop halfway until all results are in
				if (k == 5 && !paused && sent >= split) begin
					wait_for_results();
					paused = 1'b1;
				end
				if ($urandom_range(0, 99) < 8)
					send_filler($urandom_range(1, 40), -1);
				else
					send_packet(random_spec());
				sent += pkt_bytes.size();
			end
		end

		wait_for_results();
		if (miss_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
